// File: src/qbp_pkg.sv
// ----------------------------------------------------------------------------
// qbp_pkg: quadratic Bezier point package
// Shared widths, types and the rounding step of the interpolation lanes.
// ----------------------------------------------------------------------------
package qbp_pkg;

    localparam int COORD_BITS  = 16;
    localparam int T_FRAC_BITS = 16;
    localparam int RGB_BITS    = 24;
    localparam int CH_BITS     = 8;

    localparam int T_W    = T_FRAC_BITS + 1;
    localparam int LANE_W = (COORD_BITS > CH_BITS + 1) ? COORD_BITS : CH_BITS + 1;
    localparam int D_W    = LANE_W + 1;
    localparam int PROD_W = D_W + T_W + 1;

    localparam int NUM_STG   = 5;
    localparam int NUM_LANES = 5;

    localparam logic [T_W-1:0]    T_ONE = T_W'(1) << T_FRAC_BITS;
    localparam logic [PROD_W-1:0] HALF  = PROD_W'(1) << (T_FRAC_BITS - 1);

    typedef logic [T_W-1:0]           t_t;
    typedef logic signed [LANE_W-1:0] lane_t;
    typedef logic signed [D_W-1:0]    diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic [NUM_STG-1:0] en;
        t_t                 t_a;
        t_t                 t_c;
    } pipe_ctrl_t;

    function automatic lane_t round_add(lane_t p, prod_t m);
        prod_t sum;
        begin
            sum = prod_t'(p) + ((m + $signed(HALF)) >>> T_FRAC_BITS);
            return sum[LANE_W-1:0];
        end
    endfunction

    function automatic prod_t t_mul(t_t t, diff_t d);
        logic signed [T_W:0] ts;
        begin
            ts = $signed({1'b0, t});
            return prod_t'(ts) * prod_t'(d);
        end
    endfunction

endpackage

// File: src/qbp_in_if.sv
// ----------------------------------------------------------------------------
// qbp_in_if: curve input channel
// Valid/ready channel carrying three control points, their colors and t.
// ----------------------------------------------------------------------------
interface qbp_in_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [qbp_pkg::COORD_BITS-1:0]  start_x;
    logic signed [qbp_pkg::COORD_BITS-1:0]  start_y;
    logic signed [qbp_pkg::COORD_BITS-1:0]  ctrl_x;
    logic signed [qbp_pkg::COORD_BITS-1:0]  ctrl_y;
    logic signed [qbp_pkg::COORD_BITS-1:0]  end_x;
    logic signed [qbp_pkg::COORD_BITS-1:0]  end_y;
    logic [qbp_pkg::RGB_BITS-1:0]           start_rgb;
    logic [qbp_pkg::RGB_BITS-1:0]           ctrl_rgb;
    logic [qbp_pkg::RGB_BITS-1:0]           end_rgb;
    logic [qbp_pkg::T_W-1:0]                param_t;

    modport source (
        output valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
               start_rgb, ctrl_rgb, end_rgb, param_t,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
               start_rgb, ctrl_rgb, end_rgb, param_t,
        output ready
    );

endinterface

// File: src/qbp_out_if.sv
// ----------------------------------------------------------------------------
// qbp_out_if: curve point output channel
// Valid/ready channel carrying the curve point and its color.
// ----------------------------------------------------------------------------
interface qbp_out_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [qbp_pkg::COORD_BITS-1:0]  point_x;
    logic signed [qbp_pkg::COORD_BITS-1:0]  point_y;
    logic [qbp_pkg::CH_BITS-1:0]            red;
    logic [qbp_pkg::CH_BITS-1:0]            green;
    logic [qbp_pkg::CH_BITS-1:0]            blue;

    modport source (
        output valid, point_x, point_y, red, green, blue,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, red, green, blue,
        output ready
    );

endinterface

// File: src/quadratic_bezier_point_top.sv
// ----------------------------------------------------------------------------
// quadratic_bezier_point_top: quadratic Bezier point evaluator
// Channels: curve (sink) takes start/control/end points, their colors and t;
// point (source) returns the curve point and its color. Both are valid/ready;
// a transfer happens on a rising edge with valid and ready high.
// Each channel (x, y, red, green, blue) runs two-level de Casteljau
// interpolation, each step rounded to nearest; t above one acts as one.
// Path: a curve passes through the five register stages (differences,
// products, first level, second-level product, rounded result) before
// point.valid rises for its point.
// Throughput: one point per cycle while point.ready is high; two
// multipliers per lane at the first level and one at the second.
// Reset: rst_n clears all stage valid bits; point.valid drops at once.
// Stall: while point.ready is low, the result holds and earlier stages keep
// filling bubbles; curve.ready falls only when all five stages are full.
// ----------------------------------------------------------------------------
module quadratic_bezier_point_top (
    input  logic         clk,
    input  logic         rst_n,
    qbp_in_if.sink       curve,
    qbp_out_if.source    point
);

    qbp_pkg::pipe_ctrl_t ctrl;
    qbp_pkg::lane_t      p0 [qbp_pkg::NUM_LANES];
    qbp_pkg::lane_t      p1 [qbp_pkg::NUM_LANES];
    qbp_pkg::lane_t      p2 [qbp_pkg::NUM_LANES];
    qbp_pkg::lane_t      res [qbp_pkg::NUM_LANES];

    qbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (curve.valid),
        .in_ready  (curve.ready),
        .t_raw     (curve.param_t),
        .out_valid (point.valid),
        .out_ready (point.ready),
        .ctrl      (ctrl)
    );

    assign p0[0] = qbp_pkg::lane_t'(curve.start_x);
    assign p1[0] = qbp_pkg::lane_t'(curve.ctrl_x);
    assign p2[0] = qbp_pkg::lane_t'(curve.end_x);
    assign p0[1] = qbp_pkg::lane_t'(curve.start_y);
    assign p1[1] = qbp_pkg::lane_t'(curve.ctrl_y);
    assign p2[1] = qbp_pkg::lane_t'(curve.end_y);

    for (genvar c = 0; c < 3; c++)
    begin : g_color
        localparam int SH = qbp_pkg::RGB_BITS - qbp_pkg::CH_BITS * (c + 1);
        assign p0[2+c] = qbp_pkg::lane_t'({1'b0, curve.start_rgb[SH +: qbp_pkg::CH_BITS]});
        assign p1[2+c] = qbp_pkg::lane_t'({1'b0, curve.ctrl_rgb[SH +: qbp_pkg::CH_BITS]});
        assign p2[2+c] = qbp_pkg::lane_t'({1'b0, curve.end_rgb[SH +: qbp_pkg::CH_BITS]});
    end

    for (genvar l = 0; l < qbp_pkg::NUM_LANES; l++)
    begin : g_lane
        qbp_lane u_lane (
            .clk  (clk),
            .ctrl (ctrl),
            .p0   (p0[l]),
            .p1   (p1[l]),
            .p2   (p2[l]),
            .res  (res[l])
        );
    end

    assign point.point_x = res[0][qbp_pkg::COORD_BITS-1:0];
    assign point.point_y = res[1][qbp_pkg::COORD_BITS-1:0];
    assign point.red     = res[2][qbp_pkg::CH_BITS-1:0];
    assign point.green   = res[3][qbp_pkg::CH_BITS-1:0];
    assign point.blue    = res[4][qbp_pkg::CH_BITS-1:0];

endmodule

// File: src/qbp_lane.sv
// ----------------------------------------------------------------------------
// qbp_lane: one interpolation lane
// Five-stage de Casteljau datapath for one channel: differences, first-level
// products, first-level points, second-level product, rounded result.
// ----------------------------------------------------------------------------
module qbp_lane (
    input  logic                clk,
    input  qbp_pkg::pipe_ctrl_t ctrl,
    input  qbp_pkg::lane_t      p0,
    input  qbp_pkg::lane_t      p1,
    input  qbp_pkg::lane_t      p2,
    output qbp_pkg::lane_t      res
);

    qbp_pkg::lane_t p0_a_reg;
    qbp_pkg::lane_t p1_a_reg;
    qbp_pkg::diff_t d0_a_reg;
    qbp_pkg::diff_t d1_a_reg;

    qbp_pkg::lane_t p0_b_reg;
    qbp_pkg::lane_t p1_b_reg;
    qbp_pkg::prod_t m0_b_reg;
    qbp_pkg::prod_t m1_b_reg;

    qbp_pkg::lane_t q0_c_reg;
    qbp_pkg::lane_t q1_c_reg;

    qbp_pkg::lane_t q0_d_reg;
    qbp_pkg::prod_t m2_d_reg;

    qbp_pkg::lane_t res_reg;

    qbp_pkg::diff_t d0_next;
    qbp_pkg::diff_t d1_next;
    qbp_pkg::diff_t dq_next;

    assign d0_next = qbp_pkg::diff_t'(p1) - qbp_pkg::diff_t'(p0);
    assign d1_next = qbp_pkg::diff_t'(p2) - qbp_pkg::diff_t'(p1);
    assign dq_next = qbp_pkg::diff_t'(q1_c_reg) - qbp_pkg::diff_t'(q0_c_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            p0_a_reg <= p0;
            p1_a_reg <= p1;
            d0_a_reg <= d0_next;
            d1_a_reg <= d1_next;
        end
        if (ctrl.en[1])
        begin
            p0_b_reg <= p0_a_reg;
            p1_b_reg <= p1_a_reg;
            m0_b_reg <= qbp_pkg::t_mul(ctrl.t_a, d0_a_reg);
            m1_b_reg <= qbp_pkg::t_mul(ctrl.t_a, d1_a_reg);
        end
        if (ctrl.en[2])
        begin
            q0_c_reg <= qbp_pkg::round_add(p0_b_reg, m0_b_reg);
            q1_c_reg <= qbp_pkg::round_add(p1_b_reg, m1_b_reg);
        end
        if (ctrl.en[3])
        begin
            q0_d_reg <= q0_c_reg;
            m2_d_reg <= qbp_pkg::t_mul(ctrl.t_c, dq_next);
        end
        if (ctrl.en[4])
        begin
            res_reg <= qbp_pkg::round_add(q0_d_reg, m2_d_reg);
        end
    end

    assign res = res_reg;

endmodule

// File: src/qbp_ctrl.sv
// ----------------------------------------------------------------------------
// qbp_ctrl: pipeline control
// Valid bits, per-stage load enables with bubble collapse, and the t pipeline.
// ----------------------------------------------------------------------------
module qbp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qbp_pkg::t_t         t_raw,
    output logic                out_valid,
    input  logic                out_ready,
    output qbp_pkg::pipe_ctrl_t ctrl
);

    localparam int LAST = qbp_pkg::NUM_STG - 1;

    logic [qbp_pkg::NUM_STG-1:0] valid_reg;
    logic [qbp_pkg::NUM_STG-1:0] valid_next;
    logic [qbp_pkg::NUM_STG-1:0] free;
    qbp_pkg::t_t                 t_sat;
    qbp_pkg::t_t                 t_a_reg;
    qbp_pkg::t_t                 t_b_reg;
    qbp_pkg::t_t                 t_c_reg;

    always_comb
    begin
        free[LAST] = !valid_reg[LAST] || out_ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            free[i] = !valid_reg[i] || free[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (free[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < qbp_pkg::NUM_STG; i++)
        begin
            if (free[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    assign t_sat = (t_raw > qbp_pkg::T_ONE) ? qbp_pkg::T_ONE : t_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free[0])
        begin
            t_a_reg <= t_sat;
        end
        if (free[1])
        begin
            t_b_reg <= t_a_reg;
        end
        if (free[2])
        begin
            t_c_reg <= t_b_reg;
        end
    end

    assign in_ready  = free[0];
    assign out_valid = valid_reg[LAST];
    assign ctrl.en   = free;
    assign ctrl.t_a  = t_a_reg;
    assign ctrl.t_c  = t_c_reg;

`ifndef ASSERT_OFF
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg))
        else $error("input blocked with a bubble in the pipeline");

    a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted transfer did not enter the first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] && !out_ready |=> valid_reg[LAST])
        else $error("stalled result dropped");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(valid_reg[LAST-1] || valid_reg[LAST]))
        else $error("result appeared without an item behind it");

    a_t_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> (t_a_reg <= qbp_pkg::T_ONE))
        else $error("t above one entered the pipeline");
`endif

endmodule

// File: tb/sv/quadratic_bezier_point_top_tb.sv
// ----------------------------------------------------------------------------
// quadratic_bezier_point_top_tb: quadratic Bezier point evaluator testbench
// Drives curves and t values over the curve channel and checks each point
// against a local de Casteljau predictor, in order, under random idling on
// both channels, a long receiver hold-off and a stretch with no idling.
// ----------------------------------------------------------------------------
module quadratic_bezier_point_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import qbp_pkg::*;

    localparam int  IDLE_PCT    = 31;
    localparam int  HOLD_CYCLES = 300;
    localparam int  DRAIN_WAIT  = 20;
    localparam int  MAX_REPORTS = 10;
    localparam int  T_UNIT      = 1 << T_FRAC_BITS;

    typedef struct {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] ctrl_x;
        logic signed [COORD_BITS-1:0] ctrl_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic [RGB_BITS-1:0]          start_rgb;
        logic [RGB_BITS-1:0]          ctrl_rgb;
        logic [RGB_BITS-1:0]          end_rgb;
        logic [T_W-1:0]               param_t;
    } curve_t;

    typedef struct {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic [CH_BITS-1:0]           red;
        logic [CH_BITS-1:0]           green;
        logic [CH_BITS-1:0]           blue;
    } point_t;

    logic   clk;
    logic   rst_n;
    bit     steady;
    int     mismatches;
    int     hold_req;
    int     hold_ack;
    int     hold_left;
    point_t point_q[$];

    qbp_in_if  curve_if();
    qbp_out_if point_if();

    quadratic_bezier_point_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .curve (curve_if),
        .point (point_if)
    );

    always #5 clk = ~clk;

    function automatic longint lerp_q16(longint a, longint b, longint t);
        return ((longint'(T_UNIT) - t) * a + t * b + longint'(T_UNIT / 2)) >>> T_FRAC_BITS;
    endfunction

    function automatic longint bezier_eval(longint p0, longint p1, longint p2, longint t);
        return lerp_q16(lerp_q16(p0, p1, t), lerp_q16(p1, p2, t), t);
    endfunction

    function automatic point_t predict_point(curve_t c);
        point_t p;
        longint t;
        longint v;
        begin
            t = (c.param_t > T_UNIT) ? longint'(T_UNIT) : longint'(c.param_t);
            v = bezier_eval(c.start_x, c.ctrl_x, c.end_x, t);
            p.point_x = v[COORD_BITS-1:0];
            v = bezier_eval(c.start_y, c.ctrl_y, c.end_y, t);
            p.point_y = v[COORD_BITS-1:0];
            v = bezier_eval(c.start_rgb[23:16], c.ctrl_rgb[23:16], c.end_rgb[23:16], t);
            p.red = v[CH_BITS-1:0];
            v = bezier_eval(c.start_rgb[15:8], c.ctrl_rgb[15:8], c.end_rgb[15:8], t);
            p.green = v[CH_BITS-1:0];
            v = bezier_eval(c.start_rgb[7:0], c.ctrl_rgb[7:0], c.end_rgb[7:0], t);
            p.blue = v[CH_BITS-1:0];
            return p;
        end
    endfunction

    function automatic curve_t make_curve(int sx, int sy, int cx, int cy, int ex, int ey,
                                          int srgb, int crgb, int ergb, int t);
        curve_t c;
        begin
            c.start_x   = sx[COORD_BITS-1:0];
            c.start_y   = sy[COORD_BITS-1:0];
            c.ctrl_x    = cx[COORD_BITS-1:0];
            c.ctrl_y    = cy[COORD_BITS-1:0];
            c.end_x     = ex[COORD_BITS-1:0];
            c.end_y     = ey[COORD_BITS-1:0];
            c.start_rgb = srgb[RGB_BITS-1:0];
            c.ctrl_rgb  = crgb[RGB_BITS-1:0];
            c.end_rgb   = ergb[RGB_BITS-1:0];
            c.param_t   = t[T_W-1:0];
            return c;
        end
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(7))
            0:       return -32768;
            1:       return 32767;
            2:       return $urandom_range(1) ? 0 : -1;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic int rand_rgb();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 24'hFFFFFF;
            default: return int'($urandom_range(24'hFFFFFF));
        endcase
    endfunction

    function automatic int rand_t();
        case ($urandom_range(19))
            0:       return 0;
            1:       return T_UNIT;
            2, 3:    return int'($urandom_range((1 << T_W) - 1, T_UNIT + 1));
            default: return int'($urandom_range(T_UNIT));
        endcase
    endfunction

    function automatic curve_t rand_curve(int t);
        return make_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_rgb(), rand_rgb(),
                          rand_rgb(), t);
    endfunction

    task automatic send_curve(curve_t c);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            curve_if.valid <= 1'b0;
            @(negedge clk);
        end
        curve_if.valid     <= 1'b1;
        curve_if.start_x   <= c.start_x;
        curve_if.start_y   <= c.start_y;
        curve_if.ctrl_x    <= c.ctrl_x;
        curve_if.ctrl_y    <= c.ctrl_y;
        curve_if.end_x     <= c.end_x;
        curve_if.end_y     <= c.end_y;
        curve_if.start_rgb <= c.start_rgb;
        curve_if.ctrl_rgb  <= c.ctrl_rgb;
        curve_if.end_rgb   <= c.end_rgb;
        curve_if.param_t   <= c.param_t;
        @(posedge clk);
        while (!curve_if.ready)
            @(posedge clk);
        point_q.push_back(predict_point(c));
        @(negedge clk);
    endtask

    task automatic test_directed();
        send_curve(make_curve(32767, 32767, 32767, 32767, 32767, 32767,
                              24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32768));
        send_curve(make_curve(-32768, -32768, -32768, -32768, -32768, -32768,
                              0, 0, 0, 32768));
        send_curve(make_curve(32767, -32768, -32768, 32767, 32767, -32768,
                              24'hFFFFFF, 0, 24'hFFFFFF, 32768));
        send_curve(make_curve(-32768, 32767, 32767, -32768, -32768, 32767,
                              0, 24'hFFFFFF, 0, 1));
        send_curve(make_curve(1234, -4321, 32767, -32768, -7, 9, 24'h123456,
                              24'hFEDCBA, 24'h0F0F0F, 0));
        send_curve(make_curve(1234, -4321, 32767, -32768, -7, 9, 24'h123456,
                              24'hFEDCBA, 24'h0F0F0F, T_UNIT));
        send_curve(make_curve(1234, -4321, 32767, -32768, -7, 9, 24'h123456,
                              24'hFEDCBA, 24'h0F0F0F, T_UNIT + 1));
        send_curve(make_curve(-32768, 32767, 0, -1, 32767, -32768, 24'hFFFFFF,
                              24'h000000, 24'hA5A5A5, (1 << T_W) - 1));
        send_curve(make_curve(-32768, 32767, 0, -1, 32767, -32768, 24'hFFFFFF,
                              24'h000000, 24'hA5A5A5, T_UNIT - 1));
        send_curve(make_curve(0, 0, 1, -1, 0, 0, 0, 24'h010101, 0, 32768));
        send_curve(make_curve(0, 0, -1, 1, 0, 0, 24'h010101, 0, 24'h010101, 32768));
        send_curve(make_curve(-1, 0, 0, -1, -1, 0, 24'hFF0000, 24'h00FF00,
                              24'h0000FF, 21845));
        send_curve(make_curve(-1, -1, -1, -1, -1, -1, 24'h0000FF, 24'h00FF00,
                              24'hFF0000, 43691));
        send_curve(make_curve(32767, 0, -32768, 0, 32767, 0, 24'h80807F,
                              24'h7F7F80, 24'h808080, 16384));
        send_curve(make_curve(21845, -21846, 10922, -10923, 5461, -5462,
                              24'h555555, 24'hAAAAAA, 24'h555555, 49152));
        send_curve(make_curve(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_sweep();
        curve_t c;
        for (int n = 0; n < 3; n++)
        begin
            c = rand_curve(0);
            for (int k = 0; k <= 100; k++)
            begin
                c.param_t = T_W'((k * T_UNIT + 50) / 100);
                send_curve(c);
            end
        end
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
            send_curve(rand_curve(rand_t()));
    endtask

    task automatic test_backpressure();
        steady   = 1'b1;
        hold_req = hold_req + 1;
        test_random(60);
        steady   = 1'b0;
    endtask

    task automatic test_steady();
        steady = 1'b1;
        test_random(100);
        steady = 1'b0;
    endtask

    task automatic drain();
        curve_if.valid <= 1'b0;
        while (point_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            point_if.ready <= 1'b0;
        end
        else if (!steady && $urandom_range(99) < IDLE_PCT)
            point_if.ready <= 1'b0;
        else
            point_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && point_if.valid && point_if.ready)
        begin
            if (point_q.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected point x=%0d y=%0d rgb=%02h%02h%02h",
                             point_if.point_x, point_if.point_y, point_if.red,
                             point_if.green, point_if.blue);
            end
            else
            begin
                want = point_q.pop_front();
                if (point_if.point_x !== want.point_x || point_if.point_y !== want.point_y
                    || point_if.red !== want.red || point_if.green !== want.green
                    || point_if.blue !== want.blue)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("point mismatch: expected x=%0d y=%0d rgb=%02h%02h%02h, got x=%0d y=%0d rgb=%02h%02h%02h",
                                 want.point_x, want.point_y, want.red, want.green,
                                 want.blue, point_if.point_x, point_if.point_y,
                                 point_if.red, point_if.green, point_if.blue);
                end
            end
        end
    end

    initial
    begin
        #2ms;
        $display("FAIL quadratic_bezier_point_top");
        $finish;
    end

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        steady             = 1'b0;
        mismatches         = 0;
        hold_req           = 0;
        hold_ack           = 0;
        hold_left          = 0;
        curve_if.valid     = 1'b0;
        curve_if.start_x   = '0;
        curve_if.start_y   = '0;
        curve_if.ctrl_x    = '0;
        curve_if.ctrl_y    = '0;
        curve_if.end_x     = '0;
        curve_if.end_y     = '0;
        curve_if.start_rgb = '0;
        curve_if.ctrl_rgb  = '0;
        curve_if.end_rgb   = '0;
        curve_if.param_t   = '0;
        point_if.ready     = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_sweep();
        test_random(160);
        test_backpressure();
        test_random(160);
        test_steady();
        drain();

        if (mismatches == 0 && point_q.size() == 0)
            $display("PASS quadratic_bezier_point_top");
        else
            $display("FAIL quadratic_bezier_point_top");
        $finish;
    end

endmodule
